/* hdl/bce_pkg.sv */
package bce_pkg;

    localparam int MAX_DEGREE  = 6;
    localparam int POINT_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;

    localparam int NUM_POINTS = MAX_DEGREE + 1;
    localparam int T_W        = T_FRAC_BITS + 1;
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
    localparam int CFG_DEG_W  = 3;
    localparam int CFG_IDX_W  = $clog2(NUM_POINTS + 1);
    localparam int DIFF_W     = POINT_WIDTH + 1;
    localparam int PROD_W     = POINT_WIDTH + T_W + 2;
    localparam int SUM_W      = POINT_WIDTH + 2;

    // one pipeline stage per degree level, two registers each, plus the entry register
    localparam int STAGES = 1 + 2 * MAX_DEGREE;
    localparam int OCC_W  = $clog2(STAGES + 1);

    localparam logic [T_W-1:0]              T_ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic signed [PROD_W-1:0]    T_HALF = PROD_W'(2 ** (T_FRAC_BITS - 1));
    localparam logic [CFG_DEG_W-1:0]        DEG_RESET = CFG_DEG_W'(3);

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = CFG_IDX_W'(0);

    typedef logic [NUM_POINTS-1:0][POINT_WIDTH-1:0] t_points;
    typedef logic [NUM_POINTS-2:0][DIFF_W-1:0]      t_diffs;

    typedef struct packed {
        logic [T_W-1:0]   t;
        logic [DEG_W-1:0] deg;
        t_points          work;
    } t_item;

    typedef struct packed {
        logic vld_a;
        logic vld_b;
    } t_lvl_stat;

endpackage

/* hdl/bce_intf.sv */
interface bce_t_if import bce_pkg::*; ();
    logic           valid;
    logic           ready;
    logic [T_W-1:0] t_value;

    modport source (output valid, output t_value, input ready);
    modport sink   (input valid, input t_value, output ready);
endinterface

interface bce_val_if import bce_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [POINT_WIDTH-1:0] curve_value;

    modport source (output valid, output curve_value, input ready);
    modport sink   (input valid, input curve_value, output ready);
endinterface

interface bce_cfg_if import bce_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [POINT_WIDTH-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/bce_level.sv */
module bce_level import bce_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DEG_W-1:0] i_level,
    input  logic             i_vld,
    output logic             o_rdy,
    input  t_item            i_item,
    output logic             o_vld,
    input  logic             i_rdy,
    output t_item            o_item,
    output t_lvl_stat        o_stat
);

    // stage A: differences b - a
    logic             r_a_vld;
    logic [T_W-1:0]   r_a_t;
    logic [DEG_W-1:0] r_a_deg;
    logic             r_a_lerp;
    t_points          r_a_work;
    t_diffs           r_a_diff;
    t_diffs           n_diff;

    // stage B: a + round(t * (b - a))
    logic             r_b_vld;
    t_item            r_b_item;
    t_points          n_work;

    logic rdy_a;
    logic rdy_b;

    logic signed [PROD_W-1:0] prod [NUM_POINTS-1];
    logic signed [PROD_W-1:0] rnd  [NUM_POINTS-1];
    logic        [SUM_W-1:0]  sum  [NUM_POINTS-1];

    assign rdy_b = !r_b_vld || i_rdy;
    assign rdy_a = !r_a_vld || rdy_b;
    assign o_rdy = rdy_a;

    always_comb begin
        for (int i = 0; i < NUM_POINTS - 1; i++) begin
            n_diff[i] = {i_item.work[i+1][POINT_WIDTH-1], i_item.work[i+1]}
                      - {i_item.work[i][POINT_WIDTH-1], i_item.work[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_POINTS - 1; i++) begin
            prod[i] = $signed(r_a_diff[i]) * $signed({1'b0, r_a_t});
            rnd[i]  = prod[i] + T_HALF;
            // arithmetic part-select = floor division by 2^T_FRAC_BITS
            sum[i]  = {{2{r_a_work[i][POINT_WIDTH-1]}}, r_a_work[i]}
                    + rnd[i][T_FRAC_BITS +: SUM_W];
            n_work[i] = r_a_lerp ? sum[i][POINT_WIDTH-1:0] : r_a_work[i];
        end
        n_work[NUM_POINTS-1] = r_a_work[NUM_POINTS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_a_vld <= i_vld;
            end
            if (rdy_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_vld) begin
            r_a_t    <= i_item.t;
            r_a_deg  <= i_item.deg;
            r_a_lerp <= (i_item.deg >= i_level);
            r_a_work <= i_item.work;
            r_a_diff <= n_diff;
        end
        if (rdy_b && r_a_vld) begin
            r_b_item.t    <= r_a_t;
            r_b_item.deg  <= r_a_deg;
            r_b_item.work <= n_work;
        end
    end

    assign o_vld        = r_b_vld;
    assign o_item       = r_b_item;
    assign o_stat.vld_a = r_a_vld;
    assign o_stat.vld_b = r_b_vld;

    a_b_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_vld && !i_rdy) |=> (r_b_vld && $stable(r_b_item)))
        else $error("level output changed under stall");

    a_a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !rdy_b) |=> (r_a_vld && $stable(r_a_diff)))
        else $error("level stage A lost a request");

endmodule

/* hdl/bezier_curve_evaluator_top.sv */
// One-dimensional Bezier evaluator (de Casteljau), degree 1..6. Write the degree (register 0)
// and control points point_0..point_6 (registers 1..7, signed Q16.16) while no request is in
// flight; each t_value request (unsigned Q1.16, values above 1.0 clamp to 1.0) yields one
// curve_value in signed Q16.16, every interpolation rounded to nearest with ties upward.
// Degree 0 acts as degree 1, degrees above 6 as 6. The datapath is a 13-register pipeline:
// an entry register, then two registers per de Casteljau level (difference, then multiply
// and round), six levels in all; levels beyond the programmed degree pass the value through.
// One request is accepted every cycle until a stalled output backs up the whole pipeline, and
// each stage fills bubbles on its own, so requests keep entering while a result waits at the output.
module bezier_curve_evaluator_top import bce_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bce_cfg_if.sink   i_cfg,
    bce_t_if.sink     i_t,
    bce_val_if.source o_val
);

    logic [CFG_DEG_W-1:0] r_deg;
    t_points              r_pts;

    logic                 r_s0_vld;
    t_item                r_s0;
    t_item                n_s0;
    logic                 s0_rdy;

    logic                 vld_c  [MAX_DEGREE+1];
    logic                 rdy_c  [MAX_DEGREE+1];
    t_item                item_c [MAX_DEGREE+1];
    t_lvl_stat            stat   [MAX_DEGREE];
    logic [2*MAX_DEGREE-1:0] stat_vld;

    logic [OCC_W-1:0]     r_occ;
    logic                 in_acc;
    logic                 out_acc;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= DEG_RESET;
            r_pts <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_DEGREE) begin
                r_deg <= i_cfg.data[CFG_DEG_W-1:0];
            end
            for (int j = 0; j < NUM_POINTS; j++) begin
                if (i_cfg.index == CFG_IDX_W'(j + 1)) begin
                    r_pts[j] <= i_cfg.data;
                end
            end
        end
    end

    always_comb begin
        n_s0.t = (i_t.t_value > T_ONE) ? T_ONE : i_t.t_value;
        if (r_deg == '0) begin
            n_s0.deg = DEG_W'(1);
        end else if (int'(r_deg) > MAX_DEGREE) begin
            n_s0.deg = DEG_W'(MAX_DEGREE);
        end else begin
            n_s0.deg = DEG_W'(r_deg);
        end
        n_s0.work = r_pts;
    end

    assign s0_rdy    = !r_s0_vld || rdy_c[0];
    assign i_t.ready = s0_rdy;
    assign in_acc    = i_t.valid && s0_rdy;
    assign out_acc   = o_val.valid && o_val.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (s0_rdy) begin
            r_s0_vld <= i_t.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s0 <= n_s0;
        end
    end

    assign vld_c[0]  = r_s0_vld;
    assign item_c[0] = r_s0;

    for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_lvl
        bce_level u_lvl (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_level (DEG_W'(k + 1)),
            .i_vld   (vld_c[k]),
            .o_rdy   (rdy_c[k]),
            .i_item  (item_c[k]),
            .o_vld   (vld_c[k+1]),
            .i_rdy   (rdy_c[k+1]),
            .o_item  (item_c[k+1]),
            .o_stat  (stat[k])
        );
        assign stat_vld[2*k]   = stat[k].vld_a;
        assign stat_vld[2*k+1] = stat[k].vld_b;
    end

    assign rdy_c[MAX_DEGREE] = o_val.ready;
    assign o_val.valid       = vld_c[MAX_DEGREE];
    assign o_val.curve_value = item_c[MAX_DEGREE].work[0];

    // requests in flight, for checking only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            r_occ <= r_occ + OCC_W'(in_acc) - OCC_W'(out_acc);
        end
    end

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({stat_vld, r_s0_vld}) == int'(r_occ))
        else $error("pipeline valid bits disagree with requests in flight");

    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_vld |-> (r_s0.deg != '0 && r_s0.deg <= DEG_W'(MAX_DEGREE)))
        else $error("entry degree not clamped");

    a_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_vld |-> (r_s0.t <= T_ONE))
        else $error("entry t not saturated");

endmodule
